[hw/rtl/tfst_pkg.sv]
// Package for the TCP flow statistics table: sizes, flow entry type, FSM states,
// controller/datapath command and status structs. No dependencies.
package tfst_pkg;

    localparam int MaxFlows = 1024;
    localparam int IdxW     = 10;   // entry address bits
    localparam int CntW     = 11;   // fill count bits, holds MaxFlows
    localparam int InW      = 176;
    localparam int OutW     = 264;

    typedef struct packed {
        logic [39:0] t_start;
        logic [15:0] win_max;
        logic [15:0] win_min;
        logic [31:0] dst_bytes;
        logic [31:0] src_bytes;
        logic [31:0] dst_packets;
        logic [31:0] src_packets;
        logic [15:0] rst_cnt;
        logic [15:0] fin_cnt;
        logic [15:0] syn_cnt;
        logic [15:0] dport;
        logic [15:0] sport;
        logic [31:0] dst_addr;
        logic [31:0] src_addr;
    } flow_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_UPD,
        ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic              load;      // capture input item
        logic              rd;        // issue memory read at rd_addr
        logic [IdxW-1:0]   rd_addr;
        logic              upd;       // build result; write entry if not full
        logic              found;
        logic [CntW-1:0]   index;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hit;                    // registered read entry matches key
    } dp_stat_t;

endpackage

[hw/rtl/tfst_datapath.sv]
// Datapath: flow entry memory, key compare, saturating update, result register.
// Depends on tfst_pkg.
module tfst_datapath (
    input  logic                       clk,
    input  tfst_pkg::dp_cmd_t          cmd,
    input  logic [tfst_pkg::InW-1:0]   in_data,
    output tfst_pkg::dp_stat_t         stat,
    output logic [tfst_pkg::OutW-1:0]  out_data
);
    import tfst_pkg::*;

    flow_entry_t mem [MaxFlows];
    flow_entry_t rd_reg;
    logic [InW-1:0] item_reg;
    logic [OutW-1:0] out_reg;

    logic [31:0] sip, dip;
    logic [15:0] sp, dp, win, len;
    logic [7:0]  flags;
    logic [39:0] ts;
    flow_entry_t nxt;
    logic full;
    logic [32:0] s_pk, s_by;

    assign sip   = item_reg[31:0];
    assign dip   = item_reg[63:32];
    assign sp    = item_reg[79:64];
    assign dp    = item_reg[95:80];
    assign flags = item_reg[103:96];
    assign win   = item_reg[119:104];
    assign len   = item_reg[135:120];
    assign ts    = item_reg[175:136];

    // match in either direction
    assign stat.hit = (rd_reg.src_addr == sip && rd_reg.dst_addr == dip &&
                       rd_reg.sport == sp && rd_reg.dport == dp) ||
                      (rd_reg.src_addr == dip && rd_reg.dst_addr == sip &&
                       rd_reg.sport == dp && rd_reg.dport == sp);

    assign full = (cmd.index == CntW'(MaxFlows));

    // updated entry
    always_comb
    begin
        nxt = rd_reg;
        s_pk = '0;
        s_by = '0;
        if (!cmd.found) begin
            nxt.src_addr    = sip;
            nxt.dst_addr    = dip;
            nxt.sport       = sp;
            nxt.dport       = dp;
            nxt.syn_cnt     = '0;
            nxt.fin_cnt     = '0;
            nxt.rst_cnt     = '0;
            nxt.src_packets = 32'd1;
            nxt.dst_packets = '0;
            nxt.src_bytes   = {16'd0, len};
            nxt.dst_bytes   = '0;
            nxt.win_min     = win;
            nxt.win_max     = win;
            nxt.t_start     = ts;
        end else if (sip == rd_reg.src_addr) begin
            s_pk = {1'b0, rd_reg.src_packets} + 33'd1;
            s_by = {1'b0, rd_reg.src_bytes} + {17'd0, len};
            nxt.src_packets = s_pk[32] ? '1 : s_pk[31:0];
            nxt.src_bytes   = s_by[32] ? '1 : s_by[31:0];
        end else if (sip == rd_reg.dst_addr) begin
            s_pk = {1'b0, rd_reg.dst_packets} + 33'd1;
            s_by = {1'b0, rd_reg.dst_bytes} + {17'd0, len};
            nxt.dst_packets = s_pk[32] ? '1 : s_pk[31:0];
            nxt.dst_bytes   = s_by[32] ? '1 : s_by[31:0];
        end
        if (flags[1] && nxt.syn_cnt != '1) nxt.syn_cnt = nxt.syn_cnt + 16'd1;
        if (flags[0] && nxt.fin_cnt != '1) nxt.fin_cnt = nxt.fin_cnt + 16'd1;
        if (flags[2] && nxt.rst_cnt != '1) nxt.rst_cnt = nxt.rst_cnt + 16'd1;
        if (cmd.found && win > rd_reg.win_max) nxt.win_max = win;
        if (cmd.found && win < rd_reg.win_min) nxt.win_min = win;
    end

    // memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.upd && !full)
            mem[cmd.index[IdxW-1:0]] <= nxt;
        if (cmd.rd)
            rd_reg <= mem[cmd.rd_addr];
    end

    // item capture and result register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= in_data;
        if (cmd.upd) begin
            if (full)
                out_reg <= {253'd0, cmd.index};
            else
                out_reg <= {4'd0,
                            (ts >= nxt.t_start) ? ts - nxt.t_start : 40'd0,
                            nxt.win_max, nxt.win_min,
                            nxt.dst_bytes, nxt.src_bytes,
                            nxt.dst_packets, nxt.src_packets,
                            nxt.rst_cnt, nxt.fin_cnt, nxt.syn_cnt,
                            !cmd.found, cmd.index};
        end
    end

    assign out_data = out_reg;

endmodule

[hw/rtl/tfst_ctrl.sv]
// Controller: search sequencer over the used entries, fill count, handshakes.
// Depends on tfst_pkg.
module tfst_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  tfst_pkg::dp_stat_t stat,
    output tfst_pkg::dp_cmd_t  cmd
);
    import tfst_pkg::*;

    state_t state_reg, state_next;
    logic [CntW-1:0] used_reg, used_next;
    logic [CntW-1:0] k_reg, k_next;
    logic found_reg, found_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            used_reg  <= '0;
            k_reg     <= '0;
            found_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
            k_reg     <= k_next;
            found_reg <= found_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        used_next   = used_reg;
        k_next      = k_reg;
        found_next  = found_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd         = '0;
        cmd.rd_addr = k_reg[IdxW-1:0];
        cmd.index   = k_reg;
        cmd.found   = found_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    k_next     = '0;
                    found_next = 1'b0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (k_reg == used_reg) begin
                    state_next = ST_UPD;
                end else begin
                    cmd.rd     = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (stat.hit) begin
                    found_next = 1'b1;
                    cmd.rd     = 1'b1;
                    state_next = ST_UPD;
                end else begin
                    k_next     = k_reg + CntW'(1);
                    state_next = ST_READ;
                end
            end
            ST_UPD:
            begin
                cmd.upd = 1'b1;
                if (!found_reg && used_reg != CntW'(MaxFlows))
                    used_next = used_reg + CntW'(1);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // fill count never exceeds capacity
    assert property (@(posedge clk) disable iff (!rst_n) used_reg <= CntW'(MaxFlows))
        else $error("fill count above capacity");
    // search index stays within used entries
    assert property (@(posedge clk) disable iff (!rst_n) k_reg <= used_reg)
        else $error("search ran past fill count");
    // fill count grows only on an update
    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg != $past(used_reg) |-> $past(state_reg) == ST_UPD)
        else $error("fill count changed outside update");

endmodule

[hw/rtl/tcp_flow_statistics_table.sv]
// Top level of the TCP flow statistics table: controller plus datapath.
// Depends on tfst_pkg, tfst_ctrl, tfst_datapath.
//
//  channel | group          | contents
//  input   | s_axis_t*      | one parsed TCP header per transaction
//  output  | m_axis_t*      | flow statistics for that header
//
// The linear search reads one entry at a time, each read followed by a compare,
// from the single read port of the flow memory; it stops at the first hit and
// otherwise runs over every entry in use before the update.
// One item in flight; input is not taken while a result waits.
// Reset clears the fill count and control only; the memory needs no clearing.
module tcp_flow_statistics_table (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // src_ip, dst_ip, src port, dst port, tcp_flags, window, payload_bytes,
    // timestamp_us (low bit up)
    input  logic [175:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // conn_index, is_new, SYN count, FIN count, RST count, packets_from_source,
    // packets_from_dest, bytes_from_source, bytes_from_dest, window minimum,
    // window maximum, duration_us, zero pad (low bit up)
    output logic [263:0] m_axis_tdata
);
    import tfst_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    tfst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tfst_datapath u_dp (
        .clk      (clk),
        .cmd      (cmd),
        .in_data  (s_axis_tdata),
        .stat     (stat),
        .out_data (m_axis_tdata)
    );

endmodule
